// ===== hw/rtl/sandpile_toppling_grid_defines.svh =====
// Assertion macros used by the checker file of the sandpile toppling grid.
// The macros expect a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SANDPILE_TOPPLING_GRID_DEFINES_SVH
`define SANDPILE_TOPPLING_GRID_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SPG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sandpile_pkg.sv =====
// Shared types, sizes and helper functions of the sandpile toppling grid.
// Depends on nothing; the top level and the checker import it.
package sandpile_pkg;

    // Grid size and cell width.
    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int COUNT_BITS = 32;

    // Fixed field and register widths.
    localparam int CFG_W    = 7;
    localparam int ROW_IN_W = 6;
    localparam int COL_IN_W = 6;
    localparam int GRAIN_W  = 32;
    localparam int OUT_W    = 32;
    localparam int APB_DW   = 32;

    // Derived sizes.
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROWS_W     = $clog2(MAX_ROWS + 1);
    localparam int COLS_W     = $clog2(MAX_COLS + 1);
    localparam int CELL_AW    = ROW_W + COL_W;
    localparam int CELL_DEPTH = 1 << CELL_AW;
    localparam int WIN_DEPTH  = 2 * MAX_COLS;
    localparam int WIN_AW     = $clog2(WIN_DEPTH);
    localparam int SUM_W      = ((COUNT_BITS > GRAIN_W) ? COUNT_BITS : GRAIN_W) + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Register map: index = paddr / 4.
    localparam int REG_IDX_W = 1;
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

    localparam logic [CFG_W-1:0] GRID_ROWS_RST = CFG_W'(64);
    localparam logic [CFG_W-1:0] GRID_COLS_RST = CFG_W'(64);

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_STEP = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode               opcode;
        logic [ROW_IN_W-1:0]   row;
        logic [COL_IN_W-1:0]   col;
        logic [GRAIN_W-1:0]    grain_count;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] cell_count;
        logic             grid_changed;
    } t_out_item;

    // A register value of zero acts as one, and a value past the grid acts as its size.
    function automatic logic [ROWS_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        if (t == 32'd0) begin
            t = 32'd1;
        end else if (t > 32'(MAX_ROWS)) begin
            t = 32'(MAX_ROWS);
        end
        return ROWS_W'(t);
    endfunction

    function automatic logic [COLS_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        if (t == 32'd0) begin
            t = 32'd1;
        end else if (t > 32'(MAX_COLS)) begin
            t = 32'(MAX_COLS);
        end
        return COLS_W'(t);
    endfunction

endpackage

// ===== hw/rtl/sandpile_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the grid copies and the row window of the toppling grid.
module sandpile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ===== hw/rtl/sandpile_toppling_grid.sv =====
// Top level of the sandpile toppling grid: command channel, APB registers, sequencer.
// Depends on sandpile_pkg and sandpile_ram.
//
//  Channel   | Signals                              | Transfer condition
//  ----------+--------------------------------------+------------------------------------
//  command   | start, busy, i_cmd                   | start high while busy is low
//  result    | o_done, o_result                     | o_done high (one cycle, no stall)
//  registers | psel, penable, pwrite, paddr, pwdata | psel, penable, pwrite, pready high
//
// After reset the grid is cleared one cell per cycle, all CELL_DEPTH cells (4096 here),
// with busy high; register writes are taken during that time.
// An add or read passes through its own state, S_ADD or S_READ, before o_done, and an
// out-of-range or unused command raises o_done straight from idle.
// A step walks the rows of the region in turn: the shared read-add-write datapath visits
// one cell per cycle, plus one edge column per row, and then drains the pipeline.
// The result strobe cannot be held off; busy stays high while a command is in progress.
module sandpile_toppling_grid (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  sandpile_pkg::t_in_item           i_cmd,
    output logic                             o_done,
    output sandpile_pkg::t_out_item          o_result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sandpile_pkg::PADDR_W-1:0] paddr,
    input  logic [sandpile_pkg::APB_DW-1:0]  pwdata,
    output logic [sandpile_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);
    import sandpile_pkg::*;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_ADD   = 6'b000100,
        S_READ  = 6'b001000,
        S_STEP  = 6'b010000,
        S_DRAIN = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [CFG_W-1:0]        r_grid_rows, n_grid_rows;
    logic [CFG_W-1:0]        r_grid_cols, n_grid_cols;
    logic [CELL_AW-1:0]      r_clr_addr, n_clr_addr;

    // Step issue counters.
    logic [ROW_W-1:0]        r_y, n_y;
    logic [COLS_W-1:0]       r_k, n_k;
    logic                    r_cur, n_cur;
    logic                    r_changed, n_changed;

    // Data stage: RAM read data for the issued column is valid here.
    logic                    r_d_valid, n_d_valid;
    logic [COLS_W-1:0]       r_d_k, n_d_k;
    logic [ROW_W-1:0]        r_d_y, n_d_y;
    logic                    r_d_cur, n_d_cur;
    logic                    r_d_up_ok, n_d_up_ok;
    logic                    r_d_dn_ok, n_d_dn_ok;
    logic                    r_d_last, n_d_last;
    logic [COUNT_BITS-1:0]   r_cen, n_cen;
    logic [COUNT_BITS-1:0]   r_lft, n_lft;

    // Sum stage: two partial sums, added and written back.
    logic                    r_s_valid, n_s_valid;
    logic [CELL_AW-1:0]      r_s_addr, n_s_addr;
    logic [COUNT_BITS-1:0]   r_s_p1, n_s_p1;
    logic [COUNT_BITS-1:0]   r_s_p2, n_s_p2;

    // Add and read operands.
    logic [CELL_AW-1:0]      r_op_addr, n_op_addr;
    logic [GRAIN_W-1:0]      r_grain, n_grain;

    logic                    r_done, n_done;
    t_out_item               r_result, n_result;

    // Memory ports.
    logic                    grid_wr_en;
    logic [CELL_AW-1:0]      grid_wr_addr;
    logic [COUNT_BITS-1:0]   grid_wr_data;
    logic [CELL_AW-1:0]      grid_rd_addr_a, grid_rd_addr_b;
    logic [COUNT_BITS-1:0]   grid_rd_a, grid_rd_b;
    logic                    win_wr_en;
    logic [WIN_AW-1:0]       win_wr_addr;
    logic [COUNT_BITS-1:0]   win_wr_data;
    logic [WIN_AW-1:0]       win_rd_addr;
    logic [COUNT_BITS-1:0]   win_rd;

    // Decode helpers.
    logic [ROWS_W-1:0]       rows_eff;
    logic [COLS_W-1:0]       cols_eff;
    logic                    cfg_wr;
    logic [REG_IDX_W-1:0]    reg_idx;
    logic [15:0]             in_row_x, in_col_x;
    logic                    in_inside;
    logic [CELL_AW-1:0]      in_addr;
    logic [COLS_W-1:0]       km1, ccol;
    logic [ROW_W-1:0]        y_p1;
    logic                    dn_ok;
    logic [COUNT_BITS-1:0]   left_v, right_v, up_v, down_v;
    logic [SUM_W-1:0]        add_sum;
    logic [COUNT_BITS-1:0]   add_new;

    assign rows_eff = clamp_rows(r_grid_rows);
    assign cols_eff = clamp_cols(r_grid_cols);

    // Register port. Reads return the stored register, writes are never stalled.
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb begin
        case (reg_idx)
            REG_GRID_ROWS: prdata = APB_DW'(r_grid_rows);
            REG_GRID_COLS: prdata = APB_DW'(r_grid_cols);
            default:       prdata = '0;
        endcase
    end

    // Address of the commanded cell and whether it lies inside the region in use.
    assign in_row_x  = 16'(i_cmd.row);
    assign in_col_x  = 16'(i_cmd.col);
    assign in_addr   = {in_row_x[ROW_W-1:0], in_col_x[COL_W-1:0]};
    assign in_inside = (32'(i_cmd.row) < 32'(rows_eff)) && (32'(i_cmd.col) < 32'(cols_eff));

    // Saturating add of the commanded grains to the cell read in the previous cycle.
    assign add_sum = SUM_W'(grid_rd_a) + SUM_W'(r_grain);
    assign add_new = (add_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(add_sum);

    // Step issue: the center row comes from grid copy A one column ahead of the cell
    // being summed, the row below from copy B, and the old row above from the window.
    assign km1   = r_k - COLS_W'(1);
    assign y_p1  = r_y + ROW_W'(1);
    assign dn_ok = (32'(r_y) + 32'd1) < 32'(rows_eff);

    // Data stage operands. Neighbors past the region edge contribute nothing.
    assign right_v = r_d_last ? '0 : grid_rd_a;
    assign left_v  = (r_d_k >= COLS_W'(2)) ? r_lft : '0;
    assign up_v    = r_d_up_ok ? win_rd : '0;
    assign down_v  = r_d_dn_ok ? grid_rd_b : '0;
    assign ccol    = r_d_k - COLS_W'(1);

    always_comb begin
        n_state     = r_state;
        n_grid_rows = r_grid_rows;
        n_grid_cols = r_grid_cols;
        n_clr_addr  = r_clr_addr;
        n_y         = r_y;
        n_k         = r_k;
        n_cur       = r_cur;
        n_changed   = r_changed;
        n_op_addr   = r_op_addr;
        n_grain     = r_grain;
        n_done      = 1'b0;
        n_result    = '0;

        n_d_valid = 1'b0;
        n_d_k     = r_k;
        n_d_y     = r_y;
        n_d_cur   = r_cur;
        n_d_up_ok = (r_y != '0);
        n_d_dn_ok = dn_ok;
        n_d_last  = (r_k == cols_eff);

        grid_wr_en     = 1'b0;
        grid_wr_addr   = r_s_addr;
        grid_wr_data   = r_s_p1 + r_s_p2;
        grid_rd_addr_a = in_addr;
        grid_rd_addr_b = {y_p1, km1[COL_W-1:0]};
        win_rd_addr    = {~r_cur, km1[COL_W-1:0]};

        if (cfg_wr && (reg_idx == REG_GRID_ROWS)) begin
            n_grid_rows = pwdata[CFG_W-1:0];
        end
        if (cfg_wr && (reg_idx == REG_GRID_COLS)) begin
            n_grid_cols = pwdata[CFG_W-1:0];
        end

        case (r_state)
            S_CLEAR: begin
                grid_wr_en   = 1'b1;
                grid_wr_addr = r_clr_addr;
                grid_wr_data = '0;
                n_clr_addr   = r_clr_addr + CELL_AW'(1);
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op_addr = in_addr;
                    n_grain   = i_cmd.grain_count;
                    case (i_cmd.opcode)
                        OP_ADD: begin
                            if (in_inside) begin
                                n_state = S_ADD;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        OP_STEP: begin
                            n_y       = '0;
                            n_k       = '0;
                            n_cur     = 1'b0;
                            n_changed = 1'b0;
                            n_state   = S_STEP;
                        end
                        OP_READ: begin
                            if (in_inside) begin
                                n_state = S_READ;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD: begin
                grid_wr_en   = 1'b1;
                grid_wr_addr = r_op_addr;
                grid_wr_data = add_new;
                n_done       = 1'b1;
                n_state      = S_IDLE;
            end
            S_READ: begin
                n_done              = 1'b1;
                n_result.cell_count = OUT_W'(grid_rd_a);
                n_state             = S_IDLE;
            end
            S_STEP: begin
                grid_rd_addr_a = {r_y, r_k[COL_W-1:0]};
                n_d_valid      = 1'b1;
                if (r_k == cols_eff) begin
                    n_k = '0;
                    if (!dn_ok) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_y   = y_p1;
                        n_cur = ~r_cur;
                    end
                end else begin
                    n_k = r_k + COLS_W'(1);
                end
            end
            S_DRAIN: begin
                if (!r_d_valid && !r_s_valid) begin
                    n_done                = 1'b1;
                    n_result.grid_changed = r_changed;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Sum stage writes back the new count of the cell it carries.
        if (r_s_valid) begin
            grid_wr_en   = 1'b1;
            grid_wr_addr = r_s_addr;
            grid_wr_data = r_s_p1 + r_s_p2;
        end

        // A cell with four or more grains topples; flag it in the data stage.
        if (r_d_valid && (r_d_k != '0) && (r_cen[COUNT_BITS-1:2] != '0)) begin
            n_changed = 1'b1;
        end
    end

    // Data stage: keep the old center row in the window for the next row, shift the
    // three-column window, and form the partial sums. With every count in range the
    // sum of a remainder and four quarters cannot exceed the count maximum.
    always_comb begin
        win_wr_en   = r_d_valid && !r_d_last;
        win_wr_addr = {r_d_cur, r_d_k[COL_W-1:0]};
        win_wr_data = grid_rd_a;

        n_cen = r_cen;
        n_lft = r_lft;
        if (r_d_valid) begin
            n_cen = grid_rd_a;
            n_lft = r_cen;
        end

        n_s_valid = r_d_valid && (r_d_k != '0);
        n_s_addr  = {r_d_y, ccol[COL_W-1:0]};
        n_s_p1    = COUNT_BITS'(r_cen[1:0]) + (left_v >> 2) + (right_v >> 2);
        n_s_p2    = (up_v >> 2) + (down_v >> 2);
    end

    // Two identical grid copies give two independent read ports.
    sandpile_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(CELL_DEPTH)
    ) u_grid_a (
        .i_clk    (i_clk),
        .i_wr_en  (grid_wr_en),
        .i_wr_addr(grid_wr_addr),
        .i_wr_data(grid_wr_data),
        .i_rd_addr(grid_rd_addr_a),
        .o_rd_data(grid_rd_a)
    );

    sandpile_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(CELL_DEPTH)
    ) u_grid_b (
        .i_clk    (i_clk),
        .i_wr_en  (grid_wr_en),
        .i_wr_addr(grid_wr_addr),
        .i_wr_data(grid_wr_data),
        .i_rd_addr(grid_rd_addr_b),
        .o_rd_data(grid_rd_b)
    );

    // Row window: two rows of old counts, alternating between the halves.
    sandpile_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(WIN_DEPTH)
    ) u_window (
        .i_clk    (i_clk),
        .i_wr_en  (win_wr_en),
        .i_wr_addr(win_wr_addr),
        .i_wr_data(win_wr_data),
        .i_rd_addr(win_rd_addr),
        .o_rd_data(win_rd)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_grid_rows <= GRID_ROWS_RST;
            r_grid_cols <= GRID_COLS_RST;
            r_clr_addr  <= '0;
            r_d_valid   <= 1'b0;
            r_s_valid   <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_grid_rows <= n_grid_rows;
            r_grid_cols <= n_grid_cols;
            r_clr_addr  <= n_clr_addr;
            r_d_valid   <= n_d_valid;
            r_s_valid   <= n_s_valid;
            r_done      <= n_done;
        end
    end

    // Datapath and counter registers; the sequencer sets them before use.
    always_ff @(posedge i_clk) begin
        r_y       <= n_y;
        r_k       <= n_k;
        r_cur     <= n_cur;
        r_changed <= n_changed;
        r_d_k     <= n_d_k;
        r_d_y     <= n_d_y;
        r_d_cur   <= n_d_cur;
        r_d_up_ok <= n_d_up_ok;
        r_d_dn_ok <= n_d_dn_ok;
        r_d_last  <= n_d_last;
        r_cen     <= n_cen;
        r_lft     <= n_lft;
        r_s_addr  <= n_s_addr;
        r_s_p1    <= n_s_p1;
        r_s_p2    <= n_s_p2;
        r_op_addr <= n_op_addr;
        r_grain   <= n_grain;
        r_result  <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== hw/rtl/sandpile_checker.sv =====
// Port-level checker for the sandpile toppling grid, bound to the top level.
// Depends on sandpile_pkg and the macros in sandpile_toppling_grid_defines.svh.
`include "sandpile_toppling_grid_defines.svh"

module sandpile_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_done,
    input sandpile_pkg::t_out_item          o_result,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic                             pready,
    input logic [sandpile_pkg::PADDR_W-1:0] paddr,
    input logic [sandpile_pkg::APB_DW-1:0]  pwdata,
    input logic [sandpile_pkg::APB_DW-1:0]  prdata
);
    import sandpile_pkg::*;

    // A result only appears once the block has gone back to idle.
    `SPG_ASSERT_SAME(a_done_idle, o_done, !busy, "result delivered while busy")

    // An accepted command either keeps the block busy or finishes at once.
    `SPG_ASSERT_NEXT(a_accept_progress, start && !busy, busy || o_done, "command dropped")

    // Every result stems from a command that was accepted or in progress.
    `SPG_ASSERT_SAME(a_done_cause, o_done, $past(busy) || $past(start), "unprompted result")

    // A read returns a count and never a toppling flag.
    `SPG_ASSERT_SAME(a_result_kind, o_done && (o_result.cell_count != '0),
        !o_result.grid_changed, "count and toppling flag both set")

    // The row register reads back what was written to it.
    `SPG_ASSERT_NEXT(a_rows_readback,
        psel && penable && pwrite && pready && (paddr[PADDR_W-1:2] == REG_GRID_ROWS),
        (paddr[PADDR_W-1:2] != REG_GRID_ROWS) || (prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0])),
        "row register readback mismatch")

endmodule

bind sandpile_toppling_grid sandpile_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_result(o_result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
);
